// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/tcbc_pkg.sv =====
// Package: types, constants and string tables of the tuner classifier.
package tcbc_pkg;

   localparam int SCREEN_SPAN_DEF    = 240;
   localparam int BAR_LENGTH_DEF     = 221;
   localparam int FREQ_FRAC_BITS_DEF = 10;

   localparam int LOG2_BASE_Q16 = 509959;
   localparam int FULL_SCALE_CENTS = 200;
   localparam int LOG_STEPS     = 16;
   // ceil(2^32 / FULL_SCALE_CENTS)
   localparam logic [24:0] DIV_RECIP = 25'd21474837;

   localparam logic [2:0] CMD_OK        = 3'd0;
   localparam logic [2:0] CMD_NO_SIGNAL = 3'd1;
   localparam logic [2:0] CMD_DETECTING = 3'd2;
   localparam logic [2:0] CMD_TOO_LOW   = 3'd3;
   localparam logic [2:0] CMD_TOO_HIGH  = 3'd4;

   localparam logic [1:0] SIGN_NONE = 2'd0;
   localparam logic [1:0] SIGN_HIGH = 2'd1;
   localparam logic [1:0] SIGN_LOW  = 2'd2;

   localparam logic [3:0] NOTE_NO_SIGNAL = 4'd6;
   localparam logic [3:0] NOTE_TOO_HIGH  = 4'd9;

   localparam logic CSR_INSTRUMENT_MODE = 1'b0;
   localparam logic CSR_TUNE_TOLERANCE  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE, S_LOG, S_SCALE, S_SEARCH, S_DELTA, S_PROD, S_FINISH
   } tcbc_state_type;

   typedef struct packed {
      logic       load;
      logic       log_step;
      logic       scale;
      logic       search;
      logic [2:0] str_idx;
      logic       delta;
      logic       prod;
      logic       finish;
   } tcbc_cmd_type;

   typedef struct packed {
      logic cmd_valid;
      logic cmd_ok;
      logic last_str;
   } tcbc_stat_type;

   function automatic logic signed [13:0] tab_cents(input logic mode,
                                                   input logic [2:0] idx);
      logic signed [13:0] c;
      c = 14'sd0;
      if (mode) begin
         case (idx)
            3'd0: c = -14'sd1700;
            3'd1: c = -14'sd1200;
            3'd2: c = -14'sd700;
            3'd3: c = -14'sd200;
            3'd4: c = 14'sd200;
            3'd5: c = 14'sd700;
            default: c = 14'sd0;
         endcase
      end else begin
         case (idx)
            3'd0: c = -14'sd3400;
            3'd1: c = -14'sd2900;
            3'd2: c = -14'sd2400;
            3'd3: c = -14'sd1900;
            3'd4: c = -14'sd1400;
            default: c = 14'sd0;
         endcase
      end
      return c;
   endfunction

endpackage

// ===== design/tuner_cents_bar_classifier.sv =====
// Top level of the tuner cents bar classifier.
// A request (tuser = status, tdata = frequency) with an ok status is loaded
// together with the position of its leading one, then takes the log2
// fraction by repeated squaring, scales it to cents, searches each string
// of the selected table (5 bass or 6 guitar) for the nearest one, and
// rounds, scales and clamps the bar. Other statuses go straight to the
// response stage; undefined statuses are dropped. One request is in work
// at a time, and the response register frees the input side as soon as
// it is loaded.
`include "assert_macros.svh"
module tuner_cents_bar_classifier #(
   parameter int SCREEN_SPAN    = tcbc_pkg::SCREEN_SPAN_DEF,
   parameter int BAR_LENGTH     = tcbc_pkg::BAR_LENGTH_DEF,
   parameter int FREQ_FRAC_BITS = tcbc_pkg::FREQ_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // frequency[19:0], zero pad
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // note_code[3:0], cents_offset[16:4], bar_left[24:17], bar_right[32:25],
   // in_tune[33], sign_state[35:34], bar_redraw[36], bar_erase[37],
   // sign_redraw[38], note_redraw[39]
   output logic [39:0] rsp_tdata
);
   import tcbc_pkg::*;

   tcbc_cmd_type  cmd;
   tcbc_stat_type stat;

   tcbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tcbc_datapath #(
      .SCREEN_SPAN    (SCREEN_SPAN),
      .BAR_LENGTH     (BAR_LENGTH),
      .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_cmd   (req_tuser),
      .req_freq  (req_tdata[19:0]),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

   `ASSERT_IMPLY(a_note_range, clock, reset, rsp_tvalid, rsp_tdata[3:0] <= NOTE_TOO_HIGH)
   `ASSERT_IMPLY(a_sign_code, clock, reset, rsp_tvalid, rsp_tdata[35:34] != 2'b11)
   `ASSERT_IMPLY(a_draw_erase, clock, reset, rsp_tvalid, !(rsp_tdata[36] && rsp_tdata[37]))
   `ASSERT_NEXT(a_ok_busy, clock, reset, req_tvalid && req_tready && req_tuser == CMD_OK, !req_tready)

endmodule

// ===== design/tcbc_ctrl.sv =====
// Controller: sequences log2, scaling, string search and bar forming.
module tcbc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  tcbc_pkg::tcbc_stat_type stat,
   output tcbc_pkg::tcbc_cmd_type  cmd
);
   import tcbc_pkg::*;

   tcbc_state_type state_ff, state_in;
   logic [3:0]     cnt_ff, cnt_in;
   logic [2:0]     idx_ff, idx_in;
   logic           valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      valid_in    = valid_ff && !rsp_tready;
      cmd         = '0;
      cmd.str_idx = idx_ff;
      req_tready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (stat.cmd_valid) begin
                  state_in = stat.cmd_ok ? S_LOG : S_FINISH;
               end
               cnt_in = '0;
            end
         end
         S_LOG: begin
            cmd.log_step = 1'b1;
            cnt_in       = cnt_ff + 4'd1;
            if (cnt_ff == 4'(LOG_STEPS - 1)) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            idx_in    = '0;
            state_in  = S_SEARCH;
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            idx_in     = idx_ff + 3'd1;
            if (stat.last_str) begin
               state_in = S_DELTA;
            end
         end
         S_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = S_PROD;
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = valid_ff;

endmodule

// ===== design/tcbc_datapath.sv =====
// Datapath: log2 unit, string search, bar forming and shown-state.
module tcbc_datapath #(
   parameter int SCREEN_SPAN    = tcbc_pkg::SCREEN_SPAN_DEF,
   parameter int BAR_LENGTH     = tcbc_pkg::BAR_LENGTH_DEF,
   parameter int FREQ_FRAC_BITS = tcbc_pkg::FREQ_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [7:0]              csr_wdata,
   input  logic [2:0]              req_cmd,
   input  logic [19:0]             req_freq,
   input  tcbc_pkg::tcbc_cmd_type  cmd,
   output tcbc_pkg::tcbc_stat_type stat,
   output logic [39:0]             rsp_tdata
);
   import tcbc_pkg::*;

   localparam int MID_COL    = SCREEN_SPAN / 2;
   localparam int HALF_BAR   = BAR_LENGTH / 2;
   localparam int WIN_LO     = MID_COL - HALF_BAR;
   localparam int WIN_HI     = MID_COL + HALF_BAR;
   localparam int LOG_OFFSET = FREQ_FRAC_BITS * 65536 + LOG2_BASE_Q16;

   logic        mode_ff;
   logic [7:0]  tol_ff;
   logic [2:0]  cmd_ff;
   logic [4:0]  e_ff;
   logic [15:0] frac_ff;
   logic [30:0] m_ff;
   logic signed [33:0] cents_ff;
   logic [32:0] best_ff;
   logic [2:0]  bidx_ff;
   logic [16:0] rmag_ff;
   logic        neg_ff, tune_ff;
   logic [23:0] p_ff;

   logic        shown_ff, low_ff, high_ff;
   logic [7:0]  sl_ff, sr_ff;
   logic [3:0]  snote_ff;

   logic [3:0]  o_note_ff;
   logic [12:0] o_cents_ff;
   logic [7:0]  o_left_ff, o_right_ff;
   logic        o_tune_ff, o_bred_ff, o_bera_ff, o_sred_ff, o_nred_ff;
   logic [1:0]  o_sign_ff;

   logic [19:0] raw;
   logic [4:0]  lead;
   logic [61:0] sq;
   logic signed [23:0] diff;
   logic signed [33:0] dsearch, dbest;
   logic [32:0] asearch, mag;
   logic [48:0] qprod;
   logic [15:0] q;
   logic [7:0]  x0, x1;
   logic        lo_n, hi_n;
   logic [12:0] rsat;
   logic [12:0] rmag13;

   always_comb begin
      raw  = (req_freq == 20'd0) ? 20'd1 : req_freq;
      lead = 5'd0;
      for (int i = 1; i < 20; i++) begin
         if (raw[i]) lead = 5'(i);
      end
   end

   assign sq      = 62'(m_ff) * 62'(m_ff);
   assign diff    = $signed(24'({e_ff, frac_ff})) - $signed(24'(LOG_OFFSET));
   assign dsearch = cents_ff - (34'(tab_cents(mode_ff, cmd.str_idx)) <<< 16);
   assign asearch = dsearch[33] ? 33'(-dsearch) : 33'(dsearch);
   assign dbest   = cents_ff - (34'(tab_cents(mode_ff, bidx_ff)) <<< 16);
   assign mag     = dbest[33] ? 33'(-dbest) : 33'(dbest);
   assign qprod   = 49'(p_ff) * 49'(DIV_RECIP);
   assign q       = qprod[47:32];

   assign stat.cmd_valid = (req_cmd <= CMD_TOO_HIGH);
   assign stat.cmd_ok    = (req_cmd == CMD_OK);
   assign stat.last_str  = (cmd.str_idx == (mode_ff ? 3'd5 : 3'd4));

   always_comb begin
      lo_n = 1'b0;
      hi_n = 1'b0;
      x0   = 8'(MID_COL);
      x1   = 8'(MID_COL);
      if (q != 16'd0) begin
         if (neg_ff) begin
            if (q < 16'(HALF_BAR)) x0 = 8'(MID_COL - int'(q));
            else begin
               x0   = 8'(WIN_LO + 1);
               lo_n = 1'b1;
            end
         end else begin
            if (q < 16'(HALF_BAR)) x1 = 8'(MID_COL + int'(q));
            else begin
               x1   = 8'(WIN_HI - 1);
               hi_n = 1'b1;
            end
         end
      end
      rmag13 = (rmag_ff > 17'd4095) ? 13'd4095 : rmag_ff[12:0];
      rsat   = neg_ff ? 13'(-rmag13) : rmag13;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b1;
         tol_ff   <= 8'd20;
         shown_ff <= 1'b0;
         sl_ff    <= '0;
         sr_ff    <= '0;
         low_ff   <= 1'b0;
         high_ff  <= 1'b0;
         snote_ff <= NOTE_NO_SIGNAL;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_INSTRUMENT_MODE) mode_ff <= csr_wdata[0];
            if (csr_index == CSR_TUNE_TOLERANCE) tol_ff <= csr_wdata;
         end
         if (cmd.finish) begin
            if (cmd_ff == CMD_OK) begin
               if (!shown_ff || x0 != sl_ff || x1 != sr_ff) begin
                  shown_ff <= 1'b1;
                  sl_ff    <= x0;
                  sr_ff    <= x1;
               end
               low_ff   <= lo_n;
               high_ff  <= hi_n;
               snote_ff <= {1'b0, bidx_ff};
            end else begin
               shown_ff <= 1'b0;
               low_ff   <= (cmd_ff == CMD_TOO_LOW);
               high_ff  <= (cmd_ff == CMD_TOO_HIGH);
               snote_ff <= 4'(cmd_ff) + 4'd5;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         e_ff    <= lead;
         frac_ff <= '0;
         m_ff    <= 31'(raw) << (5'd30 - lead);
      end
      if (cmd.log_step) begin
         frac_ff <= {frac_ff[14:0], sq[61]};
         m_ff    <= sq[61] ? sq[61:31] : sq[60:30];
      end
      if (cmd.scale) cents_ff <= 34'(diff) * 34'sd1200;
      if (cmd.search) begin
         if (cmd.str_idx == 3'd0 || asearch < best_ff) begin
            best_ff <= asearch;
            bidx_ff <= cmd.str_idx;
         end
      end
      if (cmd.delta) begin
         rmag_ff <= 17'((mag + 33'd32768) >> 16);
         neg_ff  <= dbest[33];
         tune_ff <= mag < 33'({tol_ff, 16'd0});
      end
      if (cmd.prod) p_ff <= 24'(rmag_ff) * 24'(BAR_LENGTH - 1);
      if (cmd.finish) begin
         if (cmd_ff == CMD_OK) begin
            o_note_ff  <= {1'b0, bidx_ff};
            o_cents_ff <= rsat;
            o_left_ff  <= x0;
            o_right_ff <= x1;
            o_tune_ff  <= tune_ff;
            o_sign_ff  <= lo_n ? SIGN_LOW : (hi_n ? SIGN_HIGH : SIGN_NONE);
            o_bred_ff  <= !shown_ff || x0 != sl_ff || x1 != sr_ff;
            o_bera_ff  <= 1'b0;
            o_sred_ff  <= (lo_n != low_ff) || (hi_n != high_ff);
            o_nred_ff  <= {1'b0, bidx_ff} != snote_ff;
         end else begin
            o_note_ff  <= 4'(cmd_ff) + 4'd5;
            o_cents_ff <= '0;
            o_left_ff  <= '0;
            o_right_ff <= '0;
            o_tune_ff  <= 1'b0;
            o_sign_ff  <= (cmd_ff == CMD_TOO_LOW) ? SIGN_LOW :
                          ((cmd_ff == CMD_TOO_HIGH) ? SIGN_HIGH : SIGN_NONE);
            o_bred_ff  <= 1'b0;
            o_bera_ff  <= shown_ff;
            o_sred_ff  <= ((cmd_ff == CMD_TOO_LOW) != low_ff) ||
                          ((cmd_ff == CMD_TOO_HIGH) != high_ff);
            o_nred_ff  <= (4'(cmd_ff) + 4'd5) != snote_ff;
         end
      end
   end

   assign rsp_tdata = {o_nred_ff, o_sred_ff, o_bera_ff, o_bred_ff, o_sign_ff,
                       o_tune_ff, o_right_ff, o_left_ff, o_cents_ff, o_note_ff};

endmodule

// ===== sim/tb_tuner_cents_bar_classifier.sv =====
// Self-checking testbench of the tuner cents bar classifier: streams status and
// frequency requests, predicts each response and compares it field by field.
`timescale 1ns / 100ps
module tb_tuner_cents_bar_classifier;
   import tcbc_pkg::*;

   localparam int MID_COL  = SCREEN_SPAN_DEF / 2;
   localparam int WIN_LO   = MID_COL - BAR_LENGTH_DEF / 2;
   localparam int WIN_HI   = MID_COL + BAR_LENGTH_DEF / 2;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic              note_redraw;
      logic              sign_redraw;
      logic              bar_erase;
      logic              bar_redraw;
      logic [1:0]        sign_state;
      logic              in_tune;
      logic [7:0]        bar_right;
      logic [7:0]        bar_left;
      logic [12:0]       cents_offset;
      logic [3:0]        note_code;
   } tuner_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = 24'd0;
   logic [2:0]  req_tuser = 3'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   tuner_rsp_type expected_rsp_q[$];
   int          error_count = 0;
   bit          idle_enable = 1'b1;
   int          stall_left = 0;

   // predictor copy of configuration and shown state
   logic        mode_reg;
   logic [7:0]  tol_reg;
   logic        bar_shown;
   logic [7:0]  shown_l;
   logic [7:0]  shown_r;
   logic        low_shown;
   logic        high_shown;
   logic [3:0]  note_shown;

   tuner_cents_bar_classifier dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int string_offset(logic mode, int idx);
      int guitar[6] = '{-1700, -1200, -700, -200, 200, 700};
      int bass[5]   = '{-3400, -2900, -2400, -1900, -1400};
      return mode ? guitar[idx] : bass[idx];
   endfunction

   function automatic longint log2_fixed(logic [19:0] raw);
      int              e;
      longint unsigned m;
      logic [31:0]     frac;
      e = 19;
      frac = 32'd0;
      while (e > 0 && raw[e] == 1'b0) e--;
      m = longint'(raw) << (30 - e);
      for (int i = 0; i < LOG_STEPS; i++) begin
         m = (m * m) >> 30;
         frac = {frac[30:0], 1'b0};
         if (m >= 64'h8000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return longint'(e) * 65536 + longint'(frac);
   endfunction

   function automatic void update_marks(logic lo, logic hi, inout tuner_rsp_type r);
      r.sign_redraw = (lo != low_shown) || (hi != high_shown);
      low_shown = lo;
      high_shown = hi;
      r.sign_state = lo ? SIGN_LOW : (hi ? SIGN_HIGH : SIGN_NONE);
   endfunction

   function automatic void update_note(logic [3:0] note, inout tuner_rsp_type r);
      r.note_code = note;
      r.note_redraw = (note != note_shown);
      note_shown = note;
   endfunction

   function automatic tuner_rsp_type predict_display(logic [2:0] cmd, logic [19:0] freq);
      tuner_rsp_type r;
      longint     cents, d, best, delta, rnd, pos, x0, x1;
      longint unsigned mag;
      int         idx, n;
      logic       lo, hi;
      r = '0;
      lo = 1'b0;
      hi = 1'b0;
      idx = 0;
      best = 0;
      if (cmd != CMD_OK) begin
         r.bar_erase = bar_shown;
         bar_shown = 1'b0;
         update_marks(cmd == CMD_TOO_LOW, cmd == CMD_TOO_HIGH, r);
         update_note(4'(cmd) + 4'd5, r);
         return r;
      end
      if (freq == 20'd0) freq = 20'd1;
      n = mode_reg ? 6 : 5;
      cents = 1200 * (log2_fixed(freq) - longint'(FREQ_FRAC_BITS_DEF) * 65536
                      - LOG2_BASE_Q16);
      for (int i = 0; i < n; i++) begin
         d = cents - longint'(string_offset(mode_reg, i)) * 65536;
         if (d < 0) d = -d;
         if (i == 0 || d < best) begin
            best = d;
            idx = i;
         end
      end
      delta = cents - longint'(string_offset(mode_reg, idx)) * 65536;
      mag = (delta < 0) ? -delta : delta;
      rnd = longint'((mag + 32768) >> 16);
      if (delta < 0) rnd = -rnd;
      pos = rnd * (BAR_LENGTH_DEF - 1) / FULL_SCALE_CENTS;
      if (pos < 0) begin
         x1 = MID_COL;
         if (MID_COL + pos > WIN_LO) x0 = MID_COL + pos;
         else begin
            x0 = WIN_LO + 1;
            lo = 1'b1;
         end
      end else if (pos > 0) begin
         x0 = MID_COL;
         if (MID_COL + pos < WIN_HI) x1 = MID_COL + pos;
         else begin
            x1 = WIN_HI - 1;
            hi = 1'b1;
         end
      end else begin
         x0 = MID_COL;
         x1 = MID_COL;
      end
      if (rnd > 4095) rnd = 4095;
      if (rnd < -4095) rnd = -4095;
      r.cents_offset = 13'(rnd);
      r.bar_left = 8'(x0);
      r.bar_right = 8'(x1);
      r.in_tune = !(mag >= (longint'(tol_reg) << 16));
      if (!bar_shown || r.bar_left != shown_l || r.bar_right != shown_r) begin
         r.bar_redraw = 1'b1;
         bar_shown = 1'b1;
         shown_l = r.bar_left;
         shown_r = r.bar_right;
      end
      update_marks(lo, hi, r);
      update_note(4'(idx), r);
      return r;
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) stall_left--;
      else if (idle_enable && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
      rsp_tready <= (stall_left == 0);
   end

   always @(posedge clock) begin
      tuner_rsp_type act, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act = rsp_tdata;
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            error_count++;
         end else begin
            exp_r = expected_rsp_q.pop_front();
            if (act.note_code != exp_r.note_code) begin
               $display("%0t: note_code exp %0d act %0d", $time, exp_r.note_code,
                        act.note_code);
               error_count++;
            end
            if (act.cents_offset != exp_r.cents_offset) begin
               $display("%0t: cents_offset exp %0d act %0d", $time,
                        $signed(exp_r.cents_offset), $signed(act.cents_offset));
               error_count++;
            end
            if (act.bar_left != exp_r.bar_left) begin
               $display("%0t: bar_left exp %0d act %0d", $time, exp_r.bar_left,
                        act.bar_left);
               error_count++;
            end
            if (act.bar_right != exp_r.bar_right) begin
               $display("%0t: bar_right exp %0d act %0d", $time, exp_r.bar_right,
                        act.bar_right);
               error_count++;
            end
            if (act.in_tune != exp_r.in_tune) begin
               $display("%0t: in_tune exp %0d act %0d", $time, exp_r.in_tune, act.in_tune);
               error_count++;
            end
            if (act.sign_state != exp_r.sign_state) begin
               $display("%0t: sign_state exp %0d act %0d", $time, exp_r.sign_state,
                        act.sign_state);
               error_count++;
            end
            if (act.bar_redraw != exp_r.bar_redraw) begin
               $display("%0t: bar_redraw exp %0d act %0d", $time, exp_r.bar_redraw,
                        act.bar_redraw);
               error_count++;
            end
            if (act.bar_erase != exp_r.bar_erase) begin
               $display("%0t: bar_erase exp %0d act %0d", $time, exp_r.bar_erase,
                        act.bar_erase);
               error_count++;
            end
            if (act.sign_redraw != exp_r.sign_redraw) begin
               $display("%0t: sign_redraw exp %0d act %0d", $time, exp_r.sign_redraw,
                        act.sign_redraw);
               error_count++;
            end
            if (act.note_redraw != exp_r.note_redraw) begin
               $display("%0t: note_redraw exp %0d act %0d", $time, exp_r.note_redraw,
                        act.note_redraw);
               error_count++;
            end
         end
      end
   end

   task automatic send_request(logic [2:0] cmd, logic [19:0] freq);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {4'd0, freq};
      do @(posedge clock); while (!req_tready);
      if (cmd <= CMD_TOO_HIGH) expected_rsp_q.push_back(predict_display(cmd, freq));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] val);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_INSTRUMENT_MODE) mode_reg = val[0];
      else tol_reg = val;
   endtask

   function automatic logic [19:0] freq_near_string();
      real c, f;
      c = string_offset(mode_reg, $urandom_range(0, mode_reg ? 5 : 4))
          + $urandom_range(0, 8000) / 10.0 - 400.0;
      f = 220.0 * (2.0 ** (c / 1200.0)) * 1024.0;
      if (f > 1048575.0) f = 1048575.0;
      if (f < 0.0) f = 0.0;
      return 20'($rtoi(f));
   endfunction

   function automatic logic [19:0] freq_at_cents(real c);
      return 20'($rtoi(220.0 * (2.0 ** (c / 1200.0)) * 1024.0 + 0.5));
   endfunction

   task automatic test_directed();
      send_request(CMD_OK, 20'd0);
      send_request(CMD_OK, 20'd1);
      send_request(CMD_OK, 20'hFFFFF);
      send_request(CMD_NO_SIGNAL, 20'hFFFFF);
      send_request(CMD_DETECTING, 20'd0);
      send_request(CMD_OK, freq_at_cents(-1200.0));
      send_request(CMD_OK, freq_at_cents(-1200.0));
      send_request(CMD_TOO_LOW, 20'd5);
      send_request(CMD_TOO_HIGH, 20'd5);
      send_request(CMD_TOO_HIGH, 20'd5);
      send_request(CMD_OK, freq_at_cents(-1450.0));
      send_request(CMD_OK, freq_at_cents(-1890.0));
      send_request(CMD_OK, freq_at_cents(900.0));
      send_request(CMD_OK, freq_at_cents(-1210.0));
      send_request(3'd5, 20'd100);
      send_request(3'd6, 20'h55555);
      send_request(3'd7, 20'hAAAAA);
      send_request(CMD_OK, 20'd225280);
      send_request(CMD_NO_SIGNAL, 20'd0);
   endtask

   task automatic test_config_extremes();
      for (int m = 0; m < 2; m++) begin
         write_csr(CSR_INSTRUMENT_MODE, 8'(m));
         write_csr(CSR_TUNE_TOLERANCE, (m == 0) ? 8'd0 : 8'd200);
         send_request(CMD_OK, 20'd0);
         send_request(CMD_OK, 20'hFFFFF);
         send_request(CMD_OK, freq_at_cents(string_offset(mode_reg, 0)));
         send_request(CMD_OK, freq_at_cents(string_offset(mode_reg, 2) + 150.0));
         send_request(CMD_OK, freq_near_string());
      end
   endtask

   task automatic random_phase(int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 19);
         if (k < 13) send_request(CMD_OK, freq_near_string());
         else if (k < 16) send_request(CMD_OK, 20'($urandom));
         else if (k < 19) send_request(3'($urandom_range(1, 4)), 20'($urandom));
         else send_request(3'($urandom_range(5, 7)), 20'($urandom));
      end
   endtask

   task automatic test_random();
      for (int p = 0; p < 8; p++) begin
         write_csr(CSR_INSTRUMENT_MODE, 8'($urandom_range(0, 1)));
         case (p)
            0: write_csr(CSR_TUNE_TOLERANCE, 8'd0);
            1: write_csr(CSR_TUNE_TOLERANCE, 8'd200);
            default: write_csr(CSR_TUNE_TOLERANCE, 8'($urandom_range(0, 200)));
         endcase
         idle_enable = (p != 3);
         random_phase(30);
         if (p == 4) wait_drained();
         random_phase(30);
      end
      idle_enable = 1'b0;
      random_phase(60);
   endtask

   initial begin
      mode_reg = 1'b1;
      tol_reg = 8'd20;
      bar_shown = 1'b0;
      shown_l = 8'd0;
      shown_r = 8'd0;
      low_shown = 1'b0;
      high_shown = 1'b0;
      note_shown = NOTE_NO_SIGNAL;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_random();
      wait_drained();
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
